### src/isotp_frame_reassembler_macros.svh
// assertion macros for the iso-tp frame reassembler
`ifndef ISOTP_FRAME_REASSEMBLER_MACROS_SVH
`define ISOTP_FRAME_REASSEMBLER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ISOTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isotp same-cycle check failed");

// next-cycle implication, checked out of reset
`define ISOTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isotp next-cycle check failed");

`else

`define ISOTP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ISOTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/isotp_pkg.sv
// shared types and constants for the iso-tp frame reassembler
package isotp_pkg;

  localparam int NUM_LANES = 7;
  localparam int LANE_IDX_W = 3;
  localparam int CNT_W = 3;
  localparam int LEN_W = 12;
  localparam int ID_W = 29;
  localparam int OFS_W = 11;

  localparam logic [LANE_IDX_W-1:0] LAST_LANE = 3'd6;
  localparam logic [OFS_W-1:0] ID_OFFSET_RESET = 11'd8;

  // pci type codes from the high nibble of byte 0
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  // reported frame kind
  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_FIRST = 2'd1;
  localparam logic [1:0] KIND_CONSEC = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } lane_res_t;

endpackage

### src/isotp_lane.sv
// one payload byte lane: decides whether its byte is appended
module isotp_lane (
  input  logic [isotp_pkg::LANE_IDX_W-1:0] lane_idx,
  input  logic [isotp_pkg::LEN_W-1:0]      remaining,
  input  logic                             append_ok,
  input  logic                             first_frame,
  input  logic [7:0]                       byte_from_1,
  input  logic [7:0]                       byte_from_2,
  output isotp_pkg::lane_res_t             res
);

  logic exists;
  logic en;

  // a first frame carries payload from byte 2, so one lane fewer
  assign exists = !(first_frame && (lane_idx == isotp_pkg::LAST_LANE));
  assign en = append_ok && exists &&
              (remaining > {{(isotp_pkg::LEN_W-isotp_pkg::LANE_IDX_W){1'b0}}, lane_idx});

  always_comb begin
    res.en = en;
    if (!en) begin
      res.data = 8'h00;
    end else if (first_frame) begin
      res.data = byte_from_2;
    end else begin
      res.data = byte_from_1;
    end
  end

endmodule

### src/isotp_merge.sv
// merges the lane results into a byte count and packed payload
module isotp_merge (
  input  isotp_pkg::lane_res_t                    lanes [isotp_pkg::NUM_LANES],
  output logic [isotp_pkg::CNT_W-1:0]             count,
  output logic [8*isotp_pkg::NUM_LANES-1:0]       bytes
);

  always_comb begin
    count = '0;
    for (int i = 0; i < isotp_pkg::NUM_LANES; i++) begin
      count = count + {{(isotp_pkg::CNT_W-1){1'b0}}, lanes[i].en};
    end
  end

  // enabled lanes form a prefix, so lane order is packing order
  always_comb begin
    for (int i = 0; i < isotp_pkg::NUM_LANES; i++) begin
      bytes[8*i +: 8] = lanes[i].data;
    end
  end

endmodule

### src/isotp_frame_reassembler.sv
// top level of the iso-tp receive reassembler
//
// Takes one received CAN frame per beat and returns one status beat per
// frame, in the cycle after the frame is accepted. A new frame can be taken
// every cycle while the receiver holds out_tready high; while a result waits
// in the output register with out_tready low, in_tready is low. The rate of
// one frame per cycle is set by the message count loop: subtract, seven lane
// compares, a popcount and an add close combinationally. The flow control id is
// the frame id minus the id offset written through cfg_data, modulo 2^29.
`include "isotp_frame_reassembler_macros.svh"

module isotp_frame_reassembler (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: can_id[28:0], byte0..byte7[92:29] low byte first, pad[95:93]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,
  // out_tdata: frame_kind[1:0], appended_count[4:2], appended_bytes[60:5],
  // flow_control_needed[61], flow_control_id[90:62], message_size[102:91],
  // bytes_received[114:103], complete[115], pad[119:116]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [10:0]  cfg_data
);

  localparam int NL = isotp_pkg::NUM_LANES;
  localparam int LW = isotp_pkg::LEN_W;

  logic [isotp_pkg::OFS_W-1:0] id_offset_r;
  logic [LW-1:0] exp_r, exp_nxt;
  logic [LW-1:0] rx_r, rx_nxt;
  logic          out_valid_r;
  logic [119:0]  out_data_r, out_data_nxt;

  logic [isotp_pkg::ID_W-1:0] can_id;
  logic [7:0]    frame_byte [8];
  logic [3:0]    pci;
  logic [1:0]    kind;
  logic          append_ok;
  logic          first_frame;
  logic [LW-1:0] exp_eff;
  logic [LW-1:0] rx_eff;
  logic [LW-1:0] remaining;
  logic [isotp_pkg::CNT_W-1:0] count;
  logic [8*NL-1:0] packed_bytes;
  logic [isotp_pkg::ID_W-1:0] fc_id;
  logic          in_fire;

  isotp_pkg::lane_res_t lanes [NL];

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  assign can_id = in_tdata[28:0];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      frame_byte[i] = in_tdata[29 + 8*i +: 8];
    end
  end
  assign pci = frame_byte[0][7:4];

  always_comb begin
    kind = isotp_pkg::KIND_OTHER;
    append_ok = 1'b0;
    first_frame = 1'b0;
    exp_eff = exp_r;
    rx_eff = rx_r;
    case (pci)
      isotp_pkg::PCI_SINGLE: begin
        kind = isotp_pkg::KIND_SINGLE;
        append_ok = 1'b1;
        exp_eff = {{(LW-4){1'b0}}, frame_byte[0][3:0]};
        rx_eff = '0;
      end
      isotp_pkg::PCI_FIRST: begin
        kind = isotp_pkg::KIND_FIRST;
        append_ok = 1'b1;
        first_frame = 1'b1;
        exp_eff = {frame_byte[0][3:0], frame_byte[1]};
        rx_eff = '0;
      end
      isotp_pkg::PCI_CONSEC: begin
        kind = isotp_pkg::KIND_CONSEC;
        append_ok = 1'b1;
      end
      default: begin
        kind = isotp_pkg::KIND_OTHER;
      end
    endcase
  end

  // count never passes the announced length, so this does not wrap
  assign remaining = exp_eff - rx_eff;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    isotp_lane u_lane (
      .lane_idx    (isotp_pkg::LANE_IDX_W'(g)),
      .remaining   (remaining),
      .append_ok   (append_ok),
      .first_frame (first_frame),
      .byte_from_1 (frame_byte[g+1]),
      .byte_from_2 ((g + 2 < 8) ? frame_byte[(g+2) % 8] : 8'h00),
      .res         (lanes[g])
    );
  end

  isotp_merge u_merge (
    .lanes (lanes),
    .count (count),
    .bytes (packed_bytes)
  );

  assign exp_nxt = exp_eff;
  assign rx_nxt = rx_eff + {{(LW-isotp_pkg::CNT_W){1'b0}}, count};
  assign fc_id = can_id - {{(isotp_pkg::ID_W-isotp_pkg::OFS_W){1'b0}}, id_offset_r};

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[1:0] = kind;
    out_data_nxt[4:2] = count;
    out_data_nxt[60:5] = packed_bytes;
    out_data_nxt[61] = first_frame;
    out_data_nxt[90:62] = fc_id;
    out_data_nxt[102:91] = exp_nxt;
    out_data_nxt[114:103] = rx_nxt;
    out_data_nxt[115] = (rx_nxt == exp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_offset_r <= isotp_pkg::ID_OFFSET_RESET;
      exp_r <= '0;
      rx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        id_offset_r <= cfg_data;
      end
      if (in_fire) begin
        exp_r <= exp_nxt;
        rx_r <= rx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ISOTP_ASSERT_NOW(a_count_le_size, clk, rst_n, 1'b1, rx_r <= exp_r)
  `ISOTP_ASSERT_NEXT(a_fire_gives_beat, clk, rst_n, in_fire, out_tvalid)
  `ISOTP_ASSERT_NOW(a_fc_only_first, clk, rst_n, out_tvalid && out_tdata[61], out_tdata[1:0] == isotp_pkg::KIND_FIRST)
  `ISOTP_ASSERT_NOW(a_other_no_payload, clk, rst_n, out_tvalid && (out_tdata[1:0] == isotp_pkg::KIND_OTHER), out_tdata[4:2] == 3'd0)

endmodule

### bench/tb_top.sv
// self-checking bench for the iso-tp frame reassembler: directed frames, then random messages
module tb_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_MAX = 10;

  // one received can frame as it travels in in_tdata, can_id in the low bits
  typedef struct packed {
    logic [7:0][7:0] data;
    logic [isotp_pkg::ID_W-1:0] id;
  } can_frame_t;

  // one status beat as it travels in out_tdata, frame kind in the low bits
  typedef struct packed {
    logic [3:0]                  pad;
    logic                        done;
    logic [isotp_pkg::LEN_W-1:0] rx;
    logic [isotp_pkg::LEN_W-1:0] size;
    logic [isotp_pkg::ID_W-1:0]  fc_id;
    logic                        fc_req;
    logic [55:0]                 bytes;
    logic [isotp_pkg::CNT_W-1:0] cnt;
    logic [1:0]                  kind;
  } frame_status_t;

  class reassembly_scoreboard;
    logic [isotp_pkg::OFS_W-1:0] id_offset;
    logic [isotp_pkg::LEN_W-1:0] msg_size;
    logic [isotp_pkg::LEN_W-1:0] rx_count;
    frame_status_t               status_q[$];
    int                          errors;

    function new();
      id_offset = isotp_pkg::ID_OFFSET_RESET;
      msg_size = '0;
      rx_count = '0;
      errors = 0;
    endfunction

    // work out the status that an accepted frame must produce
    function void note_frame(can_frame_t f);
      frame_status_t s;
      logic [3:0] pci;
      int first_lane;
      bit takes;
      s = '0;
      pci = f.data[0][7:4];
      takes = 1'b1;
      first_lane = 1;
      case (pci)
        isotp_pkg::PCI_SINGLE: begin
          s.kind = isotp_pkg::KIND_SINGLE;
          rx_count = '0;
          msg_size = {8'h00, f.data[0][3:0]};
        end
        isotp_pkg::PCI_FIRST: begin
          s.kind = isotp_pkg::KIND_FIRST;
          rx_count = '0;
          msg_size = {f.data[0][3:0], f.data[1]};
          first_lane = 2;
          s.fc_req = 1'b1;
        end
        isotp_pkg::PCI_CONSEC: begin
          s.kind = isotp_pkg::KIND_CONSEC;
        end
        default: begin
          s.kind = isotp_pkg::KIND_OTHER;
          takes = 1'b0;
        end
      endcase
      if (takes) begin
        for (int lane = first_lane; lane < 8; lane++) begin
          if (rx_count < msg_size) begin
            s.bytes[8*s.cnt +: 8] = f.data[lane];
            s.cnt = s.cnt + 3'd1;
            rx_count = rx_count + 12'd1;
          end
        end
      end
      s.fc_id = f.id - {{(isotp_pkg::ID_W-isotp_pkg::OFS_W){1'b0}}, id_offset};
      s.size = msg_size;
      s.rx = rx_count;
      s.done = (rx_count == msg_size);
      status_q.insert(status_q.size(), s);
    endfunction

    function void check_status(frame_status_t got);
      frame_status_t exp;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("status beat with nothing expected: %h", got);
        return;
      end
      exp = status_q.pop_front();
      if (got.kind !== exp.kind || got.cnt !== exp.cnt || got.bytes !== exp.bytes ||
          got.fc_req !== exp.fc_req || got.fc_id !== exp.fc_id ||
          got.size !== exp.size || got.rx !== exp.rx || got.done !== exp.done) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("mismatch exp: kind=%0d cnt=%0d bytes=%h fc=%b fc_id=%h size=%0d rx=%0d done=%b",
                   exp.kind, exp.cnt, exp.bytes, exp.fc_req, exp.fc_id, exp.size, exp.rx,
                   exp.done);
          $display("         got: kind=%0d cnt=%0d bytes=%h fc=%b fc_id=%h size=%0d rx=%0d done=%b",
                   got.kind, got.cnt, got.bytes, got.fc_req, got.fc_id, got.size, got.rx,
                   got.done);
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [10:0]  cfg_data;

  reassembly_scoreboard sb = new();
  bit idle_on = 1'b1;
  int frames_sent = 0;
  int cycle_count = 0;

  isotp_frame_reassembler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_status(frame_status_t'(out_tdata));
  end

  // receiver side: random stall bursts while idling is on
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic can_frame_t rand_frame();
    can_frame_t f;
    f.id = isotp_pkg::ID_W'($urandom());
    f.data = {$urandom(), $urandom()};
    return f;
  endfunction

  // the next negedge after a beat always drives in_tvalid, so no beat is taken twice
  task automatic send_frame(can_frame_t f);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_frame(f);
    frames_sent++;
  endtask

  task automatic send_ctrl(logic [isotp_pkg::ID_W-1:0] id, logic [7:0] ctrl);
    can_frame_t f;
    f = rand_frame();
    f.id = id;
    f.data[0] = ctrl;
    send_frame(f);
  endtask

  task automatic send_single(int len);
    can_frame_t f;
    f = rand_frame();
    f.data[0] = {isotp_pkg::PCI_SINGLE, 4'(len)};
    send_frame(f);
  endtask

  // first frame plus its consecutive frames, cut short when cut is not negative
  task automatic send_message(int len, int cut);
    can_frame_t f;
    int n_cf;
    logic [3:0] sn;
    f = rand_frame();
    f.data[0] = {isotp_pkg::PCI_FIRST, len[11:8]};
    f.data[1] = len[7:0];
    send_frame(f);
    n_cf = (len > 6) ? (len - 6 + 6) / 7 : 0;
    if (cut >= 0 && cut < n_cf)
      n_cf = cut;
    sn = 4'd1;
    repeat (n_cf) begin
      f = rand_frame();
      f.data[0] = {isotp_pkg::PCI_CONSEC, sn};
      sn = sn + 4'd1;
      send_frame(f);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_offset(logic [isotp_pkg::OFS_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.id_offset = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_traffic(int n_frames);
    int stop;
    int r;
    int len;
    stop = frames_sent + n_frames;
    while (frames_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_single(($urandom_range(0, 99) < 80) ? $urandom_range(0, 7) : $urandom_range(8, 15));
      end else if (r < 70) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(81, 4095) : $urandom_range(0, 80);
        send_message(len, (len > 200) ? $urandom_range(0, 20) : -1);
      end else if (r < 80) begin
        // message abandoned before its last consecutive frame, or at times sent whole
        len = $urandom_range(7, 80);
        send_message(len, $urandom_range(0, (len + 7) / 7 - 1));
      end else if (r < 90) begin
        send_ctrl(isotp_pkg::ID_W'($urandom()), {4'($urandom_range(3, 15)), 4'($urandom())});
      end else begin
        send_ctrl(isotp_pkg::ID_W'($urandom()), {isotp_pkg::PCI_CONSEC, 4'($urandom())});
      end
    end
  endtask

  initial begin
    can_frame_t f;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, id offset at its reset value until the first offset write
    send_ctrl('0, {isotp_pkg::PCI_CONSEC, 4'h1});   // no message open yet: complete, empty
    send_ctrl('1, 8'h30);
    send_ctrl(29'h0000_0005, 8'hFF);
    send_single(0);
    f.id = '1;
    f.data = '1;
    f.data[0] = {isotp_pkg::PCI_SINGLE, 4'h7};
    send_frame(f);
    send_single(3);
    send_single(15);                                 // length above what one frame carries
    send_ctrl('1, {isotp_pkg::PCI_CONSEC, 4'h1});
    send_ctrl('0, {isotp_pkg::PCI_CONSEC, 4'h2});
    send_ctrl('0, {isotp_pkg::PCI_CONSEC, 4'h3});   // past the end: nothing appended
    send_message(0, -1);
    send_message(3, -1);
    send_message(4095, 0);
    send_message(20, 1);
    send_ctrl(29'h0ABC_DEF0, 8'h7A);                 // other type in the middle keeps the count
    send_ctrl(29'h0000_0007, {isotp_pkg::PCI_CONSEC, 4'h2});
    f.id = '0;
    f.data = '0;
    f.data[0] = {isotp_pkg::PCI_FIRST, 4'h0};
    f.data[1] = 8'd9;
    send_frame(f);
    drain();
    write_offset('0);
    send_ctrl('1, 8'hE0);
    send_ctrl('0, 8'h12);
    drain();
    write_offset('1);
    send_ctrl('0, 8'h10);
    send_ctrl(29'h0000_07FF, 8'h4F);
    send_ctrl('1, 8'h2F);
    drain();

    // random part, one id offset per phase
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph != 4 && ph != 7);
      case (ph)
        0: write_offset('0);
        1: write_offset('1);
        5: write_offset(11'd1);
        6: write_offset(11'd2046);
        7: write_offset(isotp_pkg::ID_OFFSET_RESET);
        default: write_offset(isotp_pkg::OFS_W'($urandom()));
      endcase
      if (ph == 3)
        send_message(4095, -1);
      random_traffic(130);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.status_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
